FILE: src/tma_pkg.sv
// Shared constants, types and control bundle for the trimmed-mean temperature averager.
package tma_pkg;

  // Channel count and widths
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 21;
  localparam int MAG_W       = SUM_W - 1;
  localparam int REM_W       = CNT_W - 1;
  localparam int DIV_STEPS   = MAG_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_UPDATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_MASK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TEMP       = 2'd2;

  // Reset values
  localparam logic [CNT_W-1:0]           RST_SAMPLES_PER_UPDATE = CNT_W'(4);
  localparam logic [CHANNELS-1:0]        RST_DISABLE_MASK       = '0;
  localparam logic signed [SAMPLE_W-1:0] RST_DEFAULT_TEMP       = SAMPLE_W'(250);

  // Trim threshold: more than this many rounds drops max and min
  localparam logic [CNT_W-1:0] TRIM_MIN = CNT_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Controller to lane bundle
  typedef struct packed {
    logic             sample_en;  // accept one reading into the window
    logic             first;      // first round of a window
    logic             prep;       // load divider from window totals
    logic             step;       // one divider iteration
    logic             trim;       // drop max and min
    logic [CNT_W-1:0] divisor;    // rounds left after trimming
  } lane_ctl_t;

endpackage

FILE: src/tma_lane.sv
// One channel lane: window max/min/sum and a bit-serial signed divider.
module tma_lane (
  input  logic               clk,
  input  tma_pkg::lane_ctl_t ctl,
  input  tma_pkg::sample_t   sample,
  input  logic               adc_err,
  input  tma_pkg::sample_t   default_temp,
  output tma_pkg::sample_t   avg
);

  tma_pkg::sample_t                  val;
  tma_pkg::sample_t                  hi_r;
  tma_pkg::sample_t                  lo_r;
  logic signed [tma_pkg::SUM_W-1:0]  sum_r;
  logic signed [tma_pkg::SUM_W-1:0]  sum_base;
  logic signed [tma_pkg::SUM_W-1:0]  sum_trim;
  logic signed [tma_pkg::SUM_W-1:0]  sum_abs;
  logic [tma_pkg::MAG_W-1:0]         quo_r;
  logic [tma_pkg::REM_W-1:0]         rem_r;
  logic                              neg_r;
  logic [tma_pkg::CNT_W-1:0]         rem_sh;
  logic [tma_pkg::CNT_W:0]           diff;
  logic [tma_pkg::MAG_W-1:0]         quo_signed;

  // Failed reading takes the default
  assign val = adc_err ? default_temp : sample;

  // Window accumulation
  assign sum_base = ctl.first ? '0 : sum_r;

  always_ff @(posedge clk) begin
    if (ctl.sample_en) begin
      hi_r  <= (ctl.first || (val > hi_r)) ? val : hi_r;
      lo_r  <= (ctl.first || (val < lo_r)) ? val : lo_r;
      sum_r <= sum_base + tma_pkg::SUM_W'(val);
    end
  end

  // Trimmed dividend, split into sign and magnitude
  assign sum_trim = ctl.trim ? (sum_r - tma_pkg::SUM_W'(hi_r) - tma_pkg::SUM_W'(lo_r)) : sum_r;
  assign sum_abs  = sum_trim[tma_pkg::SUM_W-1] ? -sum_trim : sum_trim;

  // Restoring division step
  assign rem_sh = {rem_r, quo_r[tma_pkg::MAG_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, ctl.divisor};

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      quo_r <= sum_abs[tma_pkg::MAG_W-1:0];
      rem_r <= '0;
      neg_r <= sum_trim[tma_pkg::SUM_W-1];
    end else if (ctl.step) begin
      if (!diff[tma_pkg::CNT_W]) begin
        rem_r <= diff[tma_pkg::REM_W-1:0];
        quo_r <= {quo_r[tma_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[tma_pkg::REM_W-1:0];
        quo_r <= {quo_r[tma_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // Truncation toward zero: divide magnitudes, then restore sign
  assign quo_signed = neg_r ? -quo_r : quo_r;
  assign avg        = quo_signed[tma_pkg::SAMPLE_W-1:0];

endmodule

FILE: src/trimmed_mean_temp_averager_unit.sv
// Top level: configuration registers, window controller, four lanes and output merge.
//
// Usage
//   Input channel in_*: one reading round (four channel samples plus ADC error
//   mask) per transaction. Output channel out_*: four averages per transaction,
//   one at the end of each window of samples_per_update rounds.
//   Config channel cfg_*: index 0 samples_per_update, 1 disable_mask,
//   2 default_temp; always ready, write only while the block is idle.
// Timing
//   A round that does not close the window is only accepted. A closing round is
//   accepted, then the lanes are prepared (ST_PREP), then the bit-serial divide
//   runs (ST_DIV, one quotient bit per cycle, all lanes in parallel), then
//   ST_DONE loads the output register once that register is free.
// Reset
//   Synchronous, active low: window count cleared, registers back to 4, 0, 250,
//   output empty.
// Stall
//   Rounds keep being accepted while a result waits in the output register;
//   the next window's result is held in the lanes until that register frees.
module trimmed_mean_temp_averager_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tma_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input rounds
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tma_pkg::SAMPLE_W-1:0]    in_ambient_sample,
  input  logic signed [tma_pkg::SAMPLE_W-1:0]    in_case_sample,
  input  logic signed [tma_pkg::SAMPLE_W-1:0]    in_charge_sample,
  input  logic signed [tma_pkg::SAMPLE_W-1:0]    in_center_sample,
  input  logic [tma_pkg::CHANNELS-1:0]           in_adc_error_mask,
  // averages
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tma_pkg::SAMPLE_W-1:0]    out_ambient_avg,
  output logic signed [tma_pkg::SAMPLE_W-1:0]    out_case_avg,
  output logic signed [tma_pkg::SAMPLE_W-1:0]    out_charge_avg,
  output logic signed [tma_pkg::SAMPLE_W-1:0]    out_center_avg
);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [tma_pkg::CNT_W-1:0]          spu_r;
  logic [tma_pkg::CHANNELS-1:0]       mask_r;
  tma_pkg::sample_t                   dflt_r;
  logic [tma_pkg::CNT_W-1:0]          round_count_r, round_count_nxt;
  logic [tma_pkg::CNT_W-1:0]          div_n_r;
  logic                               trim_r;
  logic [tma_pkg::STEP_W-1:0]         step_r, step_nxt;
  logic [tma_pkg::CNT_W-1:0]          win_len;
  logic [tma_pkg::CNT_W-1:0]          cnt_inc;
  logic                               close;
  logic                               in_fire;
  logic                               out_load;
  logic                               out_valid_r;
  tma_pkg::sample_t                   out_avg_r [tma_pkg::CHANNELS];
  tma_pkg::sample_t                   samples   [tma_pkg::CHANNELS];
  tma_pkg::sample_t                   lane_avg  [tma_pkg::CHANNELS];
  tma_pkg::lane_ctl_t                 ctl;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spu_r  <= tma_pkg::RST_SAMPLES_PER_UPDATE;
      mask_r <= tma_pkg::RST_DISABLE_MASK;
      dflt_r <= tma_pkg::RST_DEFAULT_TEMP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tma_pkg::REG_SAMPLES_PER_UPDATE: spu_r  <= cfg_data[tma_pkg::CNT_W-1:0];
        tma_pkg::REG_DISABLE_MASK:       mask_r <= cfg_data[tma_pkg::CHANNELS-1:0];
        tma_pkg::REG_DEFAULT_TEMP:       dflt_r <= cfg_data[tma_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length: zero acts as one, saturate at the maximum
  always_comb begin
    priority if (spu_r == '0) begin
      win_len = tma_pkg::CNT_W'(1);
    end else if (spu_r > tma_pkg::CNT_W'(tma_pkg::MAX_SAMPLES)) begin
      win_len = tma_pkg::CNT_W'(tma_pkg::MAX_SAMPLES);
    end else begin
      win_len = spu_r;
    end
  end

  assign in_ready = (state_r == ST_ACC);
  assign in_fire  = in_valid && in_ready;
  assign cnt_inc  = round_count_r + tma_pkg::CNT_W'(1);
  assign close    = (cnt_inc >= win_len);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Window controller
  always_comb begin
    state_nxt       = state_r;
    round_count_nxt = round_count_r;
    step_nxt        = step_r;
    unique case (state_r)
      ST_ACC: begin
        if (in_fire) begin
          round_count_nxt = close ? '0 : cnt_inc;
          if (close) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + tma_pkg::STEP_W'(1);
        if (step_r == tma_pkg::STEP_W'(tma_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_ACC;
      round_count_r <= '0;
      step_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      round_count_r <= round_count_nxt;
      step_r        <= step_nxt;
    end
  end

  // Divisor of the closing window, trimmed when more than two rounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_n_r <= tma_pkg::CNT_W'(1);
      trim_r  <= 1'b0;
    end else if (in_fire && close) begin
      trim_r  <= (cnt_inc > tma_pkg::TRIM_MIN);
      div_n_r <= (cnt_inc > tma_pkg::TRIM_MIN) ? (cnt_inc - tma_pkg::TRIM_MIN) : cnt_inc;
    end
  end

  // Lane control bundle
  always_comb begin
    ctl.sample_en = in_fire;
    ctl.first     = (round_count_r == '0);
    ctl.prep      = (state_r == ST_PREP);
    ctl.step      = (state_r == ST_DIV);
    ctl.trim      = trim_r;
    ctl.divisor   = div_n_r;
  end

  assign samples[0] = in_ambient_sample;
  assign samples[1] = in_case_sample;
  assign samples[2] = in_charge_sample;
  assign samples[3] = in_center_sample;

  // Parallel channel lanes
  for (genvar ch = 0; ch < tma_pkg::CHANNELS; ch++) begin : g_lane
    tma_lane u_lane (
      .clk          (clk),
      .ctl          (ctl),
      .sample       (samples[ch]),
      .adc_err      (in_adc_error_mask[ch]),
      .default_temp (dflt_r),
      .avg          (lane_avg[ch])
    );
  end

  // Merge: disabled channels report the default, then register the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tma_pkg::CHANNELS; i++) begin
      if (out_load) begin
        out_avg_r[i] <= mask_r[i] ? dflt_r : lane_avg[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ambient_avg = out_avg_r[0];
  assign out_case_avg    = out_avg_r[1];
  assign out_charge_avg  = out_avg_r[2];
  assign out_center_avg  = out_avg_r[3];

  // Checks
  a_close_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && close) |=> (state_r == ST_PREP))
    else $error("closing round did not start the divide");

  a_count_clear_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ACC) |-> (round_count_r == '0))
    else $error("round count not cleared while dividing");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_n_r != '0))
    else $error("zero divisor during divide");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output loaded outside the done state");

endmodule
